FILE: src/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants for the tile predictor select unit
// Item layouts, mode codes and energy sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  localparam int MaxTile   = 64;
  localparam int RowAddrW  = $clog2(MaxTile);
  localparam int PixW      = 8;
  localparam int IdxW      = 6;
  localparam int ModeCount = 4;
  localparam int ModeW     = 2;
  localparam int EnergyW   = 20;
  localparam logic [EnergyW-1:0] EnergyMax = {EnergyW{1'b1}};

  typedef enum logic [ModeW-1:0] {
    ModeLeft   = 2'd0,
    ModeTop    = 2'd1,
    ModeAvg    = 2'd2,
    ModePlanar = 2'd3
  } mode_e;

  typedef struct packed {
    logic signed [PixW-1:0] pixel;
    logic [IdxW-1:0]        row_index;
    logic [IdxW-1:0]        col_index;
    logic signed [PixW-1:0] left_context;
    logic signed [PixW-1:0] top_context;
    logic                   has_left;
    logic                   has_top;
    logic                   last_of_tile;
  } in_t;

  typedef struct packed {
    logic signed [PixW-1:0] residual_left;
    logic signed [PixW-1:0] residual_top;
    logic signed [PixW-1:0] residual_avg;
    logic signed [PixW-1:0] residual_planar;
    logic                   tile_done;
    logic [ModeW-1:0]       sel_mode;
    logic [EnergyW-1:0]     sel_energy;
  } out_t;

  typedef struct packed {
    logic advance;
    logic clear;
    logic last;
  } energy_ctl_t;

endpackage

`default_nettype wire

FILE: src/tps_ram.sv
// ----------------------------------------------------------------------------
// tps_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/tps_energy.sv
// ----------------------------------------------------------------------------
// tps_energy: per-mode residual energy accumulation and mode choice
// Adds absolute residuals into four saturating energies and picks the lowest.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_energy (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire tps_pkg::energy_ctl_t                           ctl_i,
  input  wire logic [tps_pkg::ModeCount-1:0][tps_pkg::PixW-1:0] res_i,
  output logic      [tps_pkg::ModeW-1:0]                      sel_mode_o,
  output logic      [tps_pkg::EnergyW-1:0]                    sel_energy_o
);

  logic [tps_pkg::EnergyW-1:0] energy_q [tps_pkg::ModeCount];
  logic [tps_pkg::EnergyW-1:0] energy_d [tps_pkg::ModeCount];

  always_comb begin
    logic [tps_pkg::EnergyW-1:0] base;
    logic [tps_pkg::PixW-1:0]    mag;
    logic [tps_pkg::EnergyW:0]   sum;
    for (int m = 0; m < tps_pkg::ModeCount; m++) begin
      base = ctl_i.clear ? '0 : energy_q[m];
      mag  = res_i[m][tps_pkg::PixW-1] ? (~res_i[m] + 1'b1) : res_i[m];
      sum  = {1'b0, base} + {{(tps_pkg::EnergyW + 1 - tps_pkg::PixW){1'b0}}, mag};
      energy_d[m] = sum[tps_pkg::EnergyW] ? tps_pkg::EnergyMax
                                          : sum[tps_pkg::EnergyW-1:0];
    end
  end

  always_comb begin
    logic [tps_pkg::ModeW-1:0] best;
    best = tps_pkg::ModeLeft;
    for (int m = 1; m < tps_pkg::ModeCount; m++) begin
      if (energy_d[m] < energy_d[best]) begin
        best = tps_pkg::ModeW'(m);
      end
    end
    sel_mode_o   = ctl_i.last ? best : '0;
    sel_energy_o = ctl_i.last ? energy_d[best] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < tps_pkg::ModeCount; m++) begin
        energy_q[m] <= '0;
      end
    end else if (ctl_i.advance) begin
      for (int m = 0; m < tps_pkg::ModeCount; m++) begin
        energy_q[m] <= energy_d[m];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/tile_predictor_select_unit.sv
// ----------------------------------------------------------------------------
// tile_predictor_select_unit: spatial predictor residuals and mode choice
// Forms left, top, average and planar residuals per pixel and picks the
// lowest-energy mode at the end of each tile.
// ----------------------------------------------------------------------------
// One pixel item is taken every cycle. Each item is registered in the item
// stage while the previous row is read from the row RAM, and its result is then
// registered in the output register. The pixel of the preceding item is
// forwarded when both fall on the same column, so throughput stays at one item
// per cycle; the only stall comes from the output side. Row RAM entries are not
// cleared, so a pixel on a row other than the first must follow a write to its
// column.
`default_nettype none

module tile_predictor_select_unit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire tps_pkg::in_t  in_data_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output tps_pkg::out_t      out_data_o,
  input  wire logic          out_stall_i
);

  logic                           s1_valid_q;
  tps_pkg::in_t                   s1_item_q;
  logic                           fwd_q;
  logic signed [tps_pkg::PixW-1:0] fwd_pix_q;
  logic signed [tps_pkg::PixW-1:0] prev_q;
  logic signed [tps_pkg::PixW-1:0] above_left_q;
  logic                           out_valid_q;
  tps_pkg::out_t                  out_q;
  tps_pkg::out_t                  out_d;

  logic                           s1_adv;
  logic                           in_acc;
  logic [tps_pkg::RowAddrW-1:0]   in_slot;
  logic [tps_pkg::RowAddrW-1:0]   s1_slot;
  logic signed [tps_pkg::PixW-1:0] ram_rdata;
  logic signed [tps_pkg::PixW-1:0] stored_above;
  logic signed [tps_pkg::PixW-1:0] l_pix;
  logic signed [tps_pkg::PixW-1:0] t_pix;
  logic signed [tps_pkg::PixW-1:0] d_pix;
  logic signed [tps_pkg::PixW:0]   lt_sum;
  logic signed [tps_pkg::PixW:0]   avg_wide;
  logic signed [tps_pkg::PixW-1:0] planar_pred;
  logic [tps_pkg::ModeCount-1:0][tps_pkg::PixW-1:0] res;
  tps_pkg::energy_ctl_t           ectl;
  logic [tps_pkg::ModeW-1:0]      sel_mode;
  logic [tps_pkg::EnergyW-1:0]    sel_energy;
  logic                           row_nz;
  logic                           col_nz;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_slot    = in_data_i.col_index[tps_pkg::RowAddrW-1:0];
  assign s1_slot    = s1_item_q.col_index[tps_pkg::RowAddrW-1:0];

  tps_ram #(
    .Width(tps_pkg::PixW),
    .Depth(tps_pkg::MaxTile)
  ) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_slot),
    .wdata_i(s1_item_q.pixel),
    .re_i   (in_acc),
    .raddr_i(in_slot),
    .rdata_o(ram_rdata)
  );

  assign stored_above = fwd_q ? fwd_pix_q : ram_rdata;
  assign row_nz       = (s1_item_q.row_index != '0);
  assign col_nz       = (s1_item_q.col_index != '0);

  always_comb begin
    if (col_nz) begin
      l_pix = prev_q;
    end else begin
      l_pix = s1_item_q.has_left ? s1_item_q.left_context : '0;
    end
    if (row_nz) begin
      t_pix = stored_above;
    end else begin
      t_pix = s1_item_q.has_top ? s1_item_q.top_context : '0;
    end
    d_pix = (row_nz && col_nz) ? above_left_q : '0;
  end

  assign lt_sum      = {l_pix[tps_pkg::PixW-1], l_pix} + {t_pix[tps_pkg::PixW-1], t_pix};
  assign avg_wide    = (lt_sum + {{tps_pkg::PixW{1'b0}},
                        lt_sum[tps_pkg::PixW] & lt_sum[0]}) >>> 1;
  assign planar_pred = l_pix + t_pix - d_pix;

  always_comb begin
    res[tps_pkg::ModeLeft]   = s1_item_q.pixel - l_pix;
    res[tps_pkg::ModeTop]    = s1_item_q.pixel - t_pix;
    res[tps_pkg::ModeAvg]    = s1_item_q.pixel - avg_wide[tps_pkg::PixW-1:0];
    res[tps_pkg::ModePlanar] = s1_item_q.pixel - planar_pred;
  end

  assign ectl.advance = s1_adv;
  assign ectl.clear   = !row_nz && !col_nz;
  assign ectl.last    = s1_item_q.last_of_tile;

  tps_energy u_energy (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ectl),
    .res_i       (res),
    .sel_mode_o  (sel_mode),
    .sel_energy_o(sel_energy)
  );

  always_comb begin
    out_d.residual_left   = res[tps_pkg::ModeLeft];
    out_d.residual_top    = res[tps_pkg::ModeTop];
    out_d.residual_avg    = res[tps_pkg::ModeAvg];
    out_d.residual_planar = res[tps_pkg::ModePlanar];
    out_d.tile_done       = s1_item_q.last_of_tile;
    out_d.sel_mode        = sel_mode;
    out_d.sel_energy      = sel_energy;
  end

  // advance the item stage and neighbor state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      fwd_q        <= 1'b0;
      prev_q       <= '0;
      above_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && (s1_slot == in_slot);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        prev_q       <= s1_item_q.pixel;
        above_left_q <= stored_above;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // hold payload registers unless loaded
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
      fwd_pix_q <= s1_item_q.pixel;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: bench/tile_predictor_select_unit_test.sv
// ----------------------------------------------------------------------------
// tile_predictor_select_unit_test: self-checking bench for the predictor select
// Streams tiles of signed pixels through the unit, predicts the four residuals,
// the running mode energies and the end-of-tile mode choice, and compares every
// result field by field while both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tile_predictor_select_unit_test;
  import tps_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  in_t  in_data_i = '0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;
  logic out_stall_i = 1'b0;

  tile_predictor_select_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_data_i,
    .in_stall_o,
    .out_valid_o,
    .out_data_o,
    .out_stall_i
  );

  always #2 clk_i = ~clk_i;

  in_t  pixel_items[$];
  out_t expected_results[$];
  out_t expected_now;
  bit   col_written[MaxTile];
  int   total_items = 1;
  int   accepted_count = 0;
  int   done_count = 0;
  int   fail_count = 0;
  int   send_gap_pct;
  int   out_stall_pct;

  logic signed [PixW-1:0] row_mem[MaxTile];
  logic signed [PixW-1:0] prev_px = '0;
  logic signed [PixW-1:0] above_left_px = '0;
  logic [EnergyW-1:0]     mode_energy_q[ModeCount] = '{default: '0};

  function automatic out_t predict_residuals(in_t it);
    logic [RowAddrW-1:0]    slot;
    logic signed [PixW-1:0] stored;
    logic signed [PixW-1:0] res8[ModeCount];
    int   raw[ModeCount];
    int   l, t, d, plan, mag, acc;
    mode_e best;
    out_t r;
    r = '0;
    slot = it.col_index[RowAddrW-1:0];
    stored = row_mem[slot];
    if (it.row_index == 0 && it.col_index == 0) begin
      for (int m = 0; m < ModeCount; m++) mode_energy_q[m] = '0;
    end
    if (it.col_index != 0) l = prev_px;
    else if (it.has_left) l = it.left_context;
    else l = 0;
    if (it.row_index != 0) t = stored;
    else if (it.has_top) t = it.top_context;
    else t = 0;
    d = (it.row_index != 0 && it.col_index != 0) ? int'(above_left_px) : 0;
    plan = int'($signed(8'(l + t - d)));
    raw[ModeLeft]   = int'(it.pixel) - l;
    raw[ModeTop]    = int'(it.pixel) - t;
    raw[ModeAvg]    = int'(it.pixel) - (l + t) / 2;
    raw[ModePlanar] = int'(it.pixel) - plan;
    for (int m = 0; m < ModeCount; m++) begin
      res8[m] = $signed(8'(raw[m]));
      mag = (res8[m] < 0) ? -int'(res8[m]) : int'(res8[m]);
      acc = int'(mode_energy_q[m]) + mag;
      if (acc > int'(EnergyMax)) acc = int'(EnergyMax);
      mode_energy_q[m] = acc[EnergyW-1:0];
    end
    above_left_px = stored;
    row_mem[slot] = it.pixel;
    prev_px = it.pixel;
    r.residual_left   = res8[ModeLeft];
    r.residual_top    = res8[ModeTop];
    r.residual_avg    = res8[ModeAvg];
    r.residual_planar = res8[ModePlanar];
    if (it.last_of_tile) begin
      best = ModeLeft;
      for (int m = 1; m < ModeCount; m++) begin
        if (mode_energy_q[m] < mode_energy_q[best]) best = mode_e'(m);
      end
      r.tile_done  = 1'b1;
      r.sel_mode   = best;
      r.sel_energy = mode_energy_q[best];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic in_t rand_pixel(int row, int col, int px, bit last);
    in_t it;
    it.pixel        = px[PixW-1:0];
    it.row_index    = row[IdxW-1:0];
    it.col_index    = col[IdxW-1:0];
    it.left_context = PixW'($urandom);
    it.top_context  = PixW'($urandom);
    it.has_left     = 1'($urandom);
    it.has_top      = 1'($urandom);
    it.last_of_tile = last;
    return it;
  endfunction

  // never read a row entry that has not been written since reset
  task automatic queue_pixel(in_t it);
    if (it.row_index != 0 && !col_written[it.col_index]) it.row_index = '0;
    col_written[it.col_index] = 1'b1;
    pixel_items.insert(pixel_items.size(), it);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.insert(expected_results.size(), predict_residuals(in_data_i));
        accepted_count++;
      end
      case (accepted_count * 3 / total_items)
        0: send_gap_pct = 31;
        1: send_gap_pct = 59;
        default: send_gap_pct = 0;
      endcase
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data_i  <= pixel_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no expected result pending");
          fail_count++;
        end else begin
          expected_now = expected_results.pop_front();
          check_field("residual_left", $signed(expected_now.residual_left),
                      $signed(out_data_o.residual_left));
          check_field("residual_top", $signed(expected_now.residual_top),
                      $signed(out_data_o.residual_top));
          check_field("residual_avg", $signed(expected_now.residual_avg),
                      $signed(out_data_o.residual_avg));
          check_field("residual_planar", $signed(expected_now.residual_planar),
                      $signed(out_data_o.residual_planar));
          check_field("tile_done", expected_now.tile_done, out_data_o.tile_done);
          check_field("sel_mode", expected_now.sel_mode, out_data_o.sel_mode);
          check_field("sel_energy", expected_now.sel_energy, out_data_o.sel_energy);
          if (expected_now.tile_done) done_count++;
        end
      end
      case (accepted_count * 3 / total_items)
        0: out_stall_pct = 59;
        1: out_stall_pct = 31;
        default: out_stall_pct = 0;
      endcase
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_t it;
    int  tile_w, tile_h, style, base, px, random_count;
    bit  keep_last;

    // full contexts at the tile corner, extreme samples
    it = rand_pixel(0, 0, 127, 0);
    it.has_left = 1'b1;
    it.left_context = -8'sd128;
    it.has_top = 1'b1;
    it.top_context = -8'sd128;
    queue_pixel(it);
    queue_pixel(rand_pixel(0, 1, -128, 0));
    it = rand_pixel(1, 0, 0, 0);
    it.has_left = 1'b1;
    it.left_context = 8'sd127;
    queue_pixel(it);
    queue_pixel(rand_pixel(1, 1, 127, 1));
    // absent contexts count as zero; energies tie when the second pixel has no top context
    it = rand_pixel(0, 0, 0, 0);
    it.has_left = 1'b0;
    it.has_top = 1'b0;
    it.left_context = 8'sd127;
    it.top_context = -8'sd1;
    queue_pixel(it);
    queue_pixel(rand_pixel(0, 1, 0, 1));
    // average of a negative odd sum truncates toward zero
    it = rand_pixel(0, 0, 0, 0);
    it.has_left = 1'b1;
    it.left_context = -8'sd3;
    it.has_top = 1'b1;
    it.top_context = 8'sd0;
    queue_pixel(it);
    queue_pixel(rand_pixel(0, 1, -1, 1));
    // three-row tile keeps accumulating across its rows up to its last mark
    queue_pixel(rand_pixel(0, 0, -5, 0));
    queue_pixel(rand_pixel(0, 1, 100, 0));
    queue_pixel(rand_pixel(1, 0, -100, 0));
    queue_pixel(rand_pixel(1, 1, 50, 0));
    queue_pixel(rand_pixel(2, 0, -128, 0));
    queue_pixel(rand_pixel(2, 1, 127, 1));
    // highest row and column indexes
    queue_pixel(rand_pixel(0, 62, -128, 0));
    queue_pixel(rand_pixel(0, 63, 127, 0));
    queue_pixel(rand_pixel(63, 62, 127, 0));
    queue_pixel(rand_pixel(63, 63, -128, 1));

    random_count = 0;
    while (random_count < 1510) begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(6, 1)) begin
          queue_pixel(rand_pixel($urandom_range(63), $urandom_range(63),
                                 int'($urandom_range(255)) - 128, $urandom_range(3) == 0));
          random_count++;
        end
      end else begin
        tile_w = ($urandom_range(11) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
        tile_h = (tile_w > 8) ? $urandom_range(3, 1) : $urandom_range(8, 1);
        keep_last = ($urandom_range(9) != 0);
        style = $urandom_range(3);
        base = int'($urandom_range(255)) - 128;
        for (int r = 0; r < tile_h; r++) begin
          for (int c = 0; c < tile_w; c++) begin
            case (style)
              0: px = int'($urandom_range(255)) - 128;
              1: px = base + int'($urandom_range(6)) - 3;
              2: px = $urandom_range(1) ? 127 : -128;
              default: px = base;
            endcase
            queue_pixel(rand_pixel(r, c, px,
                                   keep_last && r == tile_h - 1 && c == tile_w - 1));
          end
        end
        random_count += tile_w * tile_h;
      end
    end
    total_items = pixel_items.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_items.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);

    $display("Checked %0d pixel items; %0d tiles ended with a mode choice.",
             accepted_count, done_count);
    $display("Mix: corner cases, random tiles, stray pixels.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
